// ===== design/sha256_hash_assert.svh =====
// Assertion macros for the SHA-256 hasher.
`ifndef SHA256_HASH_ASSERT_SVH
`define SHA256_HASH_ASSERT_SVH
`define SHA_ASSERT_IMPL(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define SHA_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// ===== design/sha_pkg.sv =====
`default_nettype none
package sha_pkg;
  typedef struct packed {
    logic       fin;
    logic [7:0] data;
  } item_t;

  localparam logic [31:0] H0 [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  localparam logic [7:0] PAD_BYTE = 8'h80;
endpackage
`default_nettype wire

// ===== design/sha_fifo.sv =====
`default_nettype none
module sha_fifo #(
  parameter int DEPTH = 4
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              wr_en,
  input  sha_pkg::item_t   wr_item,
  output logic             full,
  input  wire              rd_en,
  output sha_pkg::item_t   rd_item,
  output logic             empty
);
  localparam int AW = $clog2(DEPTH);
  sha_pkg::item_t mem [DEPTH];
  logic [AW:0] wp_r, rp_r;

  assign empty = (wp_r == rp_r);
  assign full  = (wp_r[AW-1:0] == rp_r[AW-1:0]) && (wp_r[AW] != rp_r[AW]);
  assign rd_item = mem[rp_r[AW-1:0]];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wp_r[AW-1:0]] <= wr_item;
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + 1'b1;
      if (rd_en) rp_r <= rp_r + 1'b1;
    end
  end
endmodule
`default_nettype wire

// ===== design/sha_core.sv =====
`default_nettype none
module sha_core (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             q_empty,
  input  sha_pkg::item_t  q_item,
  output logic            q_pop,
  output logic            out_valid,
  input  wire             out_stall,
  output logic [31:0]     out_digest_word,
  output logic [2:0]      out_word_index,
  output logic            out_last_word
);
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_LOAD = 6'b000010, S_ROUND = 6'b000100,
    S_ADD  = 6'b001000, S_PAD  = 6'b010000, S_EMIT = 6'b100000
  } state_t;

  state_t      state_r, state_nxt;
  logic [31:0] buf_r [16];
  logic [63:0] cnt_r;
  logic [31:0] h_r [8];
  logic [31:0] v_r [8];
  logic [31:0] w_r [16];
  logic [6:0]  rnd_r;
  logic [5:0]  pad_r;
  logic        fin_r, len_done_r;
  logic [2:0]  oi_r;

  logic [5:0]  pos;
  logic [3:0]  wi;
  logic [31:0] wbuf, wsch, wcur, s0, s1, e1, e0, ch, mj, t1, t2;

  function automatic logic [31:0] rr(input logic [31:0] x, input int n);
    rr = (x >> n) | (x << (32 - n));
  endfunction

  assign pos = cnt_r[8:3];
  assign wi  = rnd_r[3:0];
  assign wbuf = buf_r[wi];
  assign s0 = rr(w_r[wi + 4'd1], 7) ^ rr(w_r[wi + 4'd1], 18) ^ (w_r[wi + 4'd1] >> 3);
  assign s1 = rr(w_r[wi + 4'd14], 17) ^ rr(w_r[wi + 4'd14], 19) ^ (w_r[wi + 4'd14] >> 10);
  assign wsch = s1 + w_r[wi + 4'd9] + s0 + w_r[wi];
  assign wcur = rnd_r[6:4] == 3'd0 ? wbuf : wsch;
  assign e1 = rr(v_r[4], 6) ^ rr(v_r[4], 11) ^ rr(v_r[4], 25);
  assign ch = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
  assign e0 = rr(v_r[0], 2) ^ rr(v_r[0], 13) ^ rr(v_r[0], 22);
  assign mj = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
  assign t1 = v_r[7] + e1 + ch + sha_pkg::K[rnd_r[5:0]] + wcur;
  assign t2 = e0 + mj;

  assign q_pop = (state_r == S_IDLE) && !q_empty;
  assign out_valid = (state_r == S_EMIT);
  assign out_digest_word = h_r[oi_r];
  assign out_word_index = oi_r;
  assign out_last_word = (oi_r == 3'd7);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (q_pop) begin
        if (pos == 6'd63) state_nxt = S_LOAD;
        else if (q_item.fin) state_nxt = S_PAD;
      end
      S_PAD: begin
        if (pad_r == 6'd63) state_nxt = S_LOAD;
      end
      S_LOAD:  state_nxt = S_ROUND;
      S_ROUND: if (rnd_r == 7'd63) state_nxt = S_ADD;
      S_ADD: begin
        if (fin_r && len_done_r) state_nxt = S_EMIT;
        else if (fin_r) state_nxt = S_PAD;
        else state_nxt = S_IDLE;
      end
      S_EMIT: if (!out_stall && oi_r == 3'd7) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Padding fills one byte per cycle from the current position to the end of the block.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      buf_r[pos[5:2]][{~pos[1:0], 3'b000} +: 8] <= q_item.fin ? sha_pkg::PAD_BYTE : q_item.data;
      pad_r <= pos + 6'd1;
    end
    if (state_r == S_PAD) begin
      if (pad_r >= 6'd56 && !(len_done_r == 1'b0 && pos >= 6'd56 && pos != 6'd0))
        buf_r[pad_r[5:2]][{~pad_r[1:0], 3'b000} +: 8] <= cnt_r[{~pad_r[2:0], 3'b000} +: 8];
      else
        buf_r[pad_r[5:2]][{~pad_r[1:0], 3'b000} +: 8] <= 8'h00;
      pad_r <= pad_r + 6'd1;
    end
    if (state_r == S_LOAD) begin
      for (int k = 0; k < 8; k++) v_r[k] <= h_r[k];
      rnd_r <= '0;
    end
    if (state_r == S_ROUND) begin
      w_r[wi] <= wcur;
      v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4]; v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0]; v_r[0] <= t1 + t2;
      rnd_r <= rnd_r + 7'd1;
    end
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      fin_r <= 1'b0;
      len_done_r <= 1'b0;
      oi_r <= '0;
      for (int k = 0; k < 8; k++) h_r[k] <= sha_pkg::H0[k];
    end else begin
      state_r <= state_nxt;
      if (q_pop && !q_item.fin) cnt_r <= cnt_r + 64'd8;
      if (q_pop && q_item.fin) begin
        fin_r <= 1'b1;
        len_done_r <= (pos < 6'd56);
      end
      if (state_r == S_ADD) begin
        for (int k = 0; k < 8; k++) h_r[k] <= h_r[k] + v_r[k];
        len_done_r <= 1'b1;
        if (fin_r && !len_done_r) pad_r <= 6'd0;
      end
      if (state_r == S_EMIT && !out_stall) begin
        oi_r <= oi_r + 3'd1;
        if (oi_r == 3'd7) begin
          for (int k = 0; k < 8; k++) h_r[k] <= sha_pkg::H0[k];
          cnt_r <= '0;
          fin_r <= 1'b0;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== design/sha256_hash.sv =====
// SHA-256 hasher fed one byte per item. Append items are queued and popped while the
// core is idle; the 64th byte of a block starts a compression (load, one round per clock,
// final add). A finish item pads the block byte by byte (twice with an extra block),
// compresses, then presents eight digest words, word 0 first.
`default_nettype none
`include "sha256_hash_assert.svh"
module sha256_hash #(
  parameter int QDEPTH = 4
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire         in_kind,
  input  wire  [7:0]  in_data_byte,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);
  sha_pkg::item_t wi, ri;
  logic full, empty, pop;
  assign wi = '{fin: in_kind, data: in_data_byte};
  assign in_stall = full;

  sha_fifo #(.DEPTH(QDEPTH)) u_q (
    .clk(clk), .rst_n(rst_n), .wr_en(in_valid && !full), .wr_item(wi), .full(full),
    .rd_en(pop), .rd_item(ri), .empty(empty));

  sha_core u_core (
    .clk(clk), .rst_n(rst_n), .q_empty(empty), .q_item(ri), .q_pop(pop),
    .out_valid(out_valid), .out_stall(out_stall), .out_digest_word(out_digest_word),
    .out_word_index(out_word_index), .out_last_word(out_last_word));

  `SHA_ASSERT_IMPL(a_pop_nonempty, clk, rst_n, pop, !empty)
  `SHA_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_word_index))
  `SHA_ASSERT_IMPL(a_no_pop_emit, clk, rst_n, out_valid, !pop)
endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
`default_nettype none
module tb;
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_kind = 1'b0;
  logic [7:0]  in_data_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  logic [31:0]  hash_state [8];
  logic [7:0]   msg_block [64];
  logic [63:0]  bit_count;
  digest_word_t pending_words [$];
  int           error_count = 0;
  bit           idle_enable = 1'b1;

  sha256_hash i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_kind(in_kind), .in_data_byte(in_data_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_digest_word(out_digest_word), .out_word_index(out_word_index),
    .out_last_word(out_last_word)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] rotr(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress_block();
    logic [31:0] v [8];
    logic [31:0] w [16];
    logic [31:0] wr, t1, t2, w2, w15;
    for (int k = 0; k < 8; k++) v[k] = hash_state[k];
    for (int r = 0; r < 64; r++) begin
      if (r < 16) begin
        wr = {msg_block[r*4], msg_block[r*4+1], msg_block[r*4+2], msg_block[r*4+3]};
      end else begin
        w2 = w[(r-2) & 15];
        w15 = w[(r-15) & 15];
        wr = (rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10)) + w[(r-7) & 15] +
             (rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3)) + w[r & 15];
      end
      w[r & 15] = wr;
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25)) +
           ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::K[r] + wr;
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22)) +
           ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int k = 0; k < 8; k++) hash_state[k] = hash_state[k] + v[k];
  endtask

  task automatic predict_hash(logic kind, logic [7:0] data);
    int pos;
    digest_word_t dw;
    pos = int'(bit_count[8:3]);
    if (!kind) begin
      msg_block[pos] = data;
      bit_count = bit_count + 64'd8;
      if (bit_count[8:3] == 6'd0) compress_block();
    end else begin
      msg_block[pos] = sha_pkg::PAD_BYTE;
      pos++;
      if (pos > 56) begin
        while (pos < 64) begin msg_block[pos] = 8'h00; pos++; end
        compress_block();
        pos = 0;
      end
      while (pos < 56) begin msg_block[pos] = 8'h00; pos++; end
      for (int k = 0; k < 8; k++) msg_block[56+k] = bit_count[63-8*k -: 8];
      compress_block();
      for (int k = 0; k < 8; k++) begin
        dw.word = hash_state[k];
        dw.index = 3'(k);
        dw.last = (k == 7);
        pending_words.push_back(dw);
      end
      for (int k = 0; k < 8; k++) hash_state[k] = sha_pkg::H0[k];
      bit_count = '0;
    end
  endtask

  // The caller ends this item at the falling edge where this task returns, either by
  // driving the next item or by deasserting in_valid for an idle period.
  task automatic send_item(logic kind, logic [7:0] data);
    if (idle_enable && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_data_byte <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_hash(kind, data);
    @(negedge clk);
  endtask

  task automatic send_message(int len);
    for (int i = 0; i < len; i++) send_item(1'b0, 8'($urandom));
    send_item(1'b1, 8'($urandom));
  endtask

  always @(negedge clk) begin
    if (idle_enable && $urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    out_stall <= 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected digest word %h", $time, out_digest_word);
        error_count++;
      end else begin
        digest_word_t exp_w;
        exp_w = pending_words.pop_front();
        if (exp_w.word !== out_digest_word || exp_w.index !== out_word_index ||
            exp_w.last !== out_last_word) begin
          $display("%0t: expected %h/%0d/%0d actual %h/%0d/%0d", $time, exp_w.word,
                   exp_w.index, exp_w.last, out_digest_word, out_word_index, out_last_word);
          error_count++;
        end
      end
    end
  end

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
  endtask

  task automatic test_empty_message();
    send_item(1'b1, 8'hff);
    send_item(1'b1, 8'h00);
  endtask

  task automatic test_padding_edges();
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'hff);
    send_item(1'b0, 8'h61);
    send_item(1'b1, 8'h00);
    send_message(56);
    send_message(127);
  endtask

  task automatic test_random_messages();
    for (int m = 0; m < 2; m++) send_message($urandom_range(0, 8));
    wait_drained();
    send_message($urandom_range(0, 8));
  endtask

  task automatic test_no_idle();
    idle_enable = 1'b0;
    send_message(3);
    send_message(0);
    send_message(20);
  endtask

  initial begin
    for (int k = 0; k < 8; k++) hash_state[k] = sha_pkg::H0[k];
    bit_count = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_empty_message();
    test_padding_edges();
    test_random_messages();
    test_no_idle();
    wait_drained();
    repeat (200) @(negedge clk);
    if (error_count == 0 && pending_words.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end
endmodule
`default_nettype wire
